// File: design/rebd_pkg.sv
// Shared types and constants for the rotary encoder and button decoder.
// Holds field widths, register indexes, button event codes and the config bundle.
// No dependencies.
package rebd_pkg;

  localparam int unsigned TsW     = 32;  // timestamp width
  localparam int unsigned MsW     = 16;  // millisecond setting width
  localparam int unsigned StepW   = 8;   // step size and threshold width
  localparam int unsigned DeltaW  = 9;   // signed delta and accumulator width
  localparam int unsigned CfgIdxW = 3;   // config register index width
  localparam int unsigned CfgDatW = 16;  // widest config register
  localparam int unsigned EvW     = 2;   // button event width

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENC_DEBOUNCE = 3'd0,
    CFG_BTN_DEBOUNCE = 3'd1,
    CFG_LONG_PRESS   = 3'd2,
    CFG_DOUBLE_CLICK = 3'd3,
    CFG_STEP_SIZE    = 3'd4,
    CFG_DETENT       = 3'd5
  } cfg_idx_e;

  typedef enum logic [EvW-1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_DOUBLE = 2'd3
  } btn_event_e;

  typedef struct packed {
    logic [MsW-1:0]   enc_gap_ms;
    logic [MsW-1:0]   btn_settle_ms;
    logic [MsW-1:0]   hold_long_ms;
    logic [MsW-1:0]   dbl_window_ms;
    logic [StepW-1:0] step_size;
    logic [StepW-1:0] detent_threshold;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    enc_gap_ms:       16'd5,
    btn_settle_ms:    16'd20,
    hold_long_ms:     16'd800,
    dbl_window_ms:    16'd400,
    step_size:        8'd1,
    detent_threshold: 8'd2
  };

endpackage

// File: design/rebd_enc.sv
// Encoder channel decoder: sample gap, raw step accumulation, detent reporting.
// Depends on rebd_pkg.
module rebd_enc (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic [rebd_pkg::TsW-1:0]            now_ms_i,
  input  logic                                pin_a_i,
  input  logic                                pin_b_i,
  input  rebd_pkg::cfg_t                      cfg_i,
  output logic signed [rebd_pkg::DeltaW-1:0]  delta_o
);
  import rebd_pkg::*;

  logic [TsW-1:0]           sample_time_q, sample_time_d;
  logic                     prev_a_q, prev_a_d;
  logic signed [DeltaW-1:0] accum_q, accum_d;
  logic [TsW-1:0]           since_sample;
  logic                     sample_en;
  logic signed [DeltaW-1:0] accum_step;
  logic signed [DeltaW-1:0] accum_mag;
  logic signed [DeltaW-1:0] step_signed;

  always_comb begin
    since_sample  = now_ms_i - sample_time_q;
    sample_en     = since_sample > TsW'(cfg_i.enc_gap_ms);
    accum_step    = (pin_a_i == pin_b_i) ? accum_q + DeltaW'(1) : accum_q - DeltaW'(1);
    accum_mag     = accum_step[DeltaW-1] ? -accum_step : accum_step;
    step_signed   = $signed({1'b0, cfg_i.step_size});
    sample_time_d = sample_time_q;
    prev_a_d      = prev_a_q;
    accum_d       = accum_q;
    delta_o       = '0;
    if (sample_en) begin
      sample_time_d = now_ms_i;
      prev_a_d      = pin_a_i;
      if (pin_a_i != prev_a_q) begin
        accum_d = accum_step;
        // magnitude never exceeds 255, so the top bit is clear here
        if ($unsigned(accum_mag) >= {1'b0, cfg_i.detent_threshold}) begin
          delta_o = accum_step[DeltaW-1] ? -step_signed : step_signed;
          accum_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_time_q <= '0;
      prev_a_q      <= 1'b1;
      accum_q       <= '0;
    end else if (step_i) begin
      sample_time_q <= sample_time_d;
      prev_a_q      <= prev_a_d;
      accum_q       <= accum_d;
    end
  end

endmodule

// File: design/rebd_btn.sv
// Button debouncer and press classifier (short, long, double press).
// Depends on rebd_pkg.
module rebd_btn (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [rebd_pkg::TsW-1:0]  now_ms_i,
  input  logic                      pin_button_i,
  input  rebd_pkg::cfg_t            cfg_i,
  output rebd_pkg::btn_event_e      event_o
);
  import rebd_pkg::*;

  logic [TsW-1:0] change_time_q, change_time_d;
  logic           raw_prev_q, raw_prev_d;
  logic           stable_q, stable_d;
  logic [TsW-1:0] press_time_q, press_time_d;
  logic [TsW-1:0] click_time_q, click_time_d;
  logic           raw_changed;
  logic           settled;
  logic [TsW-1:0] held;
  logic [TsW-1:0] since_click;
  logic           is_long;
  logic           is_double;
  logic           released;

  always_comb begin
    raw_changed   = pin_button_i != raw_prev_q;
    // a change this poll restarts the window, so it cannot settle now
    settled       = !raw_changed && ((now_ms_i - change_time_q) > TsW'(cfg_i.btn_settle_ms));
    held          = now_ms_i - press_time_q;
    since_click   = now_ms_i - click_time_q;
    is_long       = held >= TsW'(cfg_i.hold_long_ms);
    is_double     = (click_time_q != '0) && (since_click < TsW'(cfg_i.dbl_window_ms));
    released      = settled && pin_button_i && !stable_q;

    change_time_d = raw_changed ? now_ms_i : change_time_q;
    raw_prev_d    = pin_button_i;
    stable_d      = settled ? pin_button_i : stable_q;
    press_time_d  = (settled && !pin_button_i && stable_q) ? now_ms_i : press_time_q;
    click_time_d  = click_time_q;
    event_o       = EV_NONE;
    if (released) begin
      if (is_long) begin
        event_o = EV_LONG;
      end else if (is_double) begin
        event_o      = EV_DOUBLE;
        click_time_d = '0;
      end else begin
        event_o      = EV_SHORT;
        click_time_d = now_ms_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      change_time_q <= '0;
      raw_prev_q    <= 1'b1;
      stable_q      <= 1'b1;
      press_time_q  <= '0;
      click_time_q  <= '0;
    end else if (step_i) begin
      change_time_q <= change_time_d;
      raw_prev_q    <= raw_prev_d;
      stable_q      <= stable_d;
      press_time_q  <= press_time_d;
      click_time_q  <= click_time_d;
    end
  end

endmodule

// File: design/rotary_encoder_button_decoder.sv
// Top level of the rotary encoder and button decoder.
// Depends on rebd_pkg, rebd_enc and rebd_btn.
//
// Usage:
//   Each input item is one poll: a 32-bit millisecond timestamp plus the raw
//   A, B and active-low button levels. Every poll gives exactly one result
//   item: a signed rotation delta (0 if no detent) and a button event code
//   (none, short, long, double press).
//   Channels use valid/ready; an item moves when valid and ready are both high.
//   Configuration is a write port (enable, index, 16-bit data), registered
//   when enabled; write it only while no poll is in flight. A zero step size or
//   detent threshold is stored as 1; indexes past the last register are dropped.
//   Path: a poll accepted into the input register moves on to the result
//   register, where its result waits until it is taken.
//   Throughput: one poll per cycle unless the result waits; the decode is a
//   few 32-bit subtracts and compares between the input register and the result register.
//   Stall: while the result waits, the input register still takes one more
//   poll, then ready drops until the result is taken.
//   Reset: both registers empty, config at defaults, the stored A and button
//   levels taken high, timestamps and the accumulator cleared.
module rotary_encoder_button_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // poll input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rebd_pkg::TsW-1:0]            now_ms_i,
  input  logic                                pin_a_i,
  input  logic                                pin_b_i,
  input  logic                                pin_button_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rebd_pkg::DeltaW-1:0]  delta_o,
  output logic [rebd_pkg::EvW-1:0]            button_event_o,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [rebd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [rebd_pkg::CfgDatW-1:0]        cfg_wdata_i
);
  import rebd_pkg::*;

  // configuration registers
  cfg_t cfg_q, cfg_d;
  logic [StepW-1:0] wdata8;

  // input register
  logic           in_valid_q;
  logic [TsW-1:0] now_q;
  logic           pin_a_q, pin_b_q, pin_button_q;

  // result register
  logic                     out_valid_q;
  logic signed [DeltaW-1:0] delta_q;
  btn_event_e               event_q;

  logic                     advance;
  logic signed [DeltaW-1:0] delta_new;
  btn_event_e               event_new;

  // Config write: clamp zero step and threshold to one, drop unknown indexes.
  always_comb begin
    wdata8 = cfg_wdata_i[StepW-1:0];
    cfg_d  = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ENC_DEBOUNCE: cfg_d.enc_gap_ms       = cfg_wdata_i;
        CFG_BTN_DEBOUNCE: cfg_d.btn_settle_ms    = cfg_wdata_i;
        CFG_LONG_PRESS:   cfg_d.hold_long_ms     = cfg_wdata_i;
        CFG_DOUBLE_CLICK: cfg_d.dbl_window_ms    = cfg_wdata_i;
        CFG_STEP_SIZE:    cfg_d.step_size        = (wdata8 == '0) ? StepW'(1) : wdata8;
        CFG_DETENT:       cfg_d.detent_threshold = (wdata8 == '0) ? StepW'(1) : wdata8;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Advance the held poll into the result register when that slot frees up.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      now_q        <= now_ms_i;
      pin_a_q      <= pin_a_i;
      pin_b_q      <= pin_b_i;
      pin_button_q <= pin_button_i;
    end
  end

  // Decoder state advances only with the poll that leaves the input register.
  rebd_enc u_enc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .now_ms_i (now_q),
    .pin_a_i  (pin_a_q),
    .pin_b_i  (pin_b_q),
    .cfg_i    (cfg_q),
    .delta_o  (delta_new)
  );

  rebd_btn u_btn (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .now_ms_i     (now_q),
    .pin_button_i (pin_button_q),
    .cfg_i        (cfg_q),
    .event_o      (event_new)
  );

  // result register: fill on advance, drain on take
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      delta_q <= delta_new;
      event_q <= event_new;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign delta_o        = delta_q;
  assign button_event_o = event_q;

endmodule

// File: design/rebd_checker.sv
// Port-level checks for the rotary encoder and button decoder.
// Depends on rebd_pkg; bound to rotary_encoder_button_decoder below.
module rebd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [rebd_pkg::DeltaW-1:0]  delta_o,
  input logic [rebd_pkg::EvW-1:0]            button_event_o
);
  import rebd_pkg::*;

  logic out_take;
  logic ev_seen_q;

  assign out_take = out_valid_o && out_ready_i;

  // remember whether the last taken result carried a button event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_seen_q <= 1'b0;
    end else if (out_take) begin
      ev_seen_q <= button_event_o != EV_NONE;
    end
  end

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(delta_o) && $stable(button_event_o))
    else $error("result changed while stalled");

  // a free result slot always lets the next poll in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input blocked with free result slot");

  // a release needs a debounced press in between, so events never follow back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && button_event_o != EV_NONE |-> !ev_seen_q)
    else $error("button events on consecutive results");

  // delta is never the most negative code, since its magnitude is at most the step size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> delta_o != $signed({1'b1, {(DeltaW-1){1'b0}}}))
    else $error("delta out of range");

  // no result right out of reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind rotary_encoder_button_decoder rebd_checker u_rebd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .delta_o        (delta_o),
  .button_event_o (button_event_o)
);
